// ===== rtl/rcsp_pkg.sv =====
// shared types, character codes and number limits for the command stream parser
package rcsp_pkg;

  // signed range of command counts and argument lengths
  localparam int NUMBER_BITS = 32;
  localparam int COUNT_BITS  = NUMBER_BITS - 1;

  localparam logic [NUMBER_BITS-1:0] LIM_POS = {1'b0, {(NUMBER_BITS-1){1'b1}}};
  localparam logic [NUMBER_BITS-1:0] LIM_NEG = {1'b1, {(NUMBER_BITS-1){1'b0}}};

  // character codes
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // parser phase
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_INLINE  = 3'd1,
    PH_COUNT   = 3'd2,
    PH_ELEM    = 3'd3,
    PH_LEN     = 3'd4,
    PH_BADLINE = 3'd5,
    PH_DATA    = 3'd6,
    PH_TRAILER = 3'd7
  } phase_t;

  // number scanner stage
  typedef enum logic [1:0] {
    NS_LEAD   = 2'd0,
    NS_SIGN   = 2'd1,
    NS_DIGITS = 2'd2,
    NS_DONE   = 2'd3
  } num_stage_t;

  // control from the parser to the number scanner
  typedef struct packed {
    logic advance;
    logic clr;
    logic feed_cr;
    logic feed_byte;
  } num_ctl_t;

  // status of the number scanned so far
  typedef struct packed {
    logic                   ok;
    logic                   negative;
    logic                   zero;
    logic [NUMBER_BITS-1:0] value;
  } num_stat_t;

  // whitespace: space, tab, lf, vt, ff, cr
  function automatic logic is_ws(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

// ===== rtl/rcsp_number.sv =====
// decimal number scanner for count and length lines
module rcsp_number import rcsp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  num_ctl_t   ctl,
  input  logic [7:0] in_byte,
  output num_stat_t  stat
);

  typedef struct packed {
    logic                   neg;
    logic                   bad;
    num_stage_t             stage;
    logic [NUMBER_BITS-1:0] value;
  } num_reg_t;

  num_reg_t num_r, num_nxt, after_cr;

  // one character into the scanner: whitespace, sign, digits, then ignore the rest
  function automatic num_reg_t feed(num_reg_t s, logic [7:0] c);
    logic                   digit;
    logic                   acc;
    logic [NUMBER_BITS+3:0] prod;
    logic [NUMBER_BITS+3:0] lim;
    num_reg_t               n;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    acc   = 1'b0;
    n     = s;
    case (s.stage)
      NS_LEAD: begin
        if (is_ws(c)) begin
          acc = 1'b0;
        end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
          n.neg   = (c == CH_MINUS);
          n.stage = NS_SIGN;
        end else if (!digit) begin
          n.bad   = 1'b1;
          n.stage = NS_DONE;
        end else begin
          n.stage = NS_DIGITS;
          acc     = 1'b1;
        end
      end
      NS_SIGN: begin
        if (!digit) begin
          n.bad   = 1'b1;
          n.stage = NS_DONE;
        end else begin
          n.stage = NS_DIGITS;
          acc     = 1'b1;
        end
      end
      NS_DIGITS: begin
        if (!digit) begin
          n.stage = NS_DONE;
        end else begin
          acc = 1'b1;
        end
      end
      default: begin
        acc = 1'b0;
      end
    endcase
    // accumulate with range check against the signed limit
    prod = ({4'b0, s.value} << 3) + ({4'b0, s.value} << 1)
         + {{NUMBER_BITS{1'b0}}, c[3:0]};
    lim  = {4'b0, (n.neg ? LIM_NEG : LIM_POS)};
    if (acc && !s.bad) begin
      if (prod > lim) begin
        n.bad = 1'b1;
      end else begin
        n.value = prod[NUMBER_BITS-1:0];
      end
    end
    return n;
  endfunction

  // held cr is fed first, then the byte itself
  always_comb begin
    after_cr = ctl.feed_cr ? feed(num_r, CH_CR) : num_r;
    num_nxt  = ctl.feed_byte ? feed(after_cr, in_byte) : after_cr;
    if (ctl.clr) begin
      num_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r <= '0;
    end else if (ctl.advance) begin
      num_r <= num_nxt;
    end
  end

  // status
  assign stat.ok       = !num_r.bad && ((num_r.stage == NS_DIGITS) || (num_r.stage == NS_DONE));
  assign stat.negative = num_r.neg;
  assign stat.zero     = (num_r.value == '0);
  assign stat.value    = num_r.value;

endmodule

// ===== rtl/resp_command_stream_parser.sv =====
// top level: request byte stream splitter into command arguments
// One result leaves for every request byte, and a new byte is taken in every cycle unless a
// held result is stalled: the parser state, the decimal accumulator and the result register all
// advance in the same cycle the byte is accepted, so throughput is one byte per clock while the
// output drains. in_ready follows out_ready while a result is held, so a stalled output stalls
// the input on the same edge. Inline commands (first byte not '*') give their words with arg_end
// on the delimiting whitespace; array commands give each bulk argument's bytes with arg_end on
// the last data byte (or on the length line for empty ones) and cmd_end on the command's last
// byte. protocol_error comes with cmd_end on a malformed command; drop its arguments.
module resp_command_stream_parser import rcsp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_arg_end,
  output logic       out_cmd_end,
  output logic       out_protocol_error,
  output logic       out_inline_form
);

  phase_t                phase_r, phase_nxt;
  logic                  prev_cr_r, prev_cr_nxt;
  logic [COUNT_BITS-1:0] args_left_r, args_left_nxt;
  logic [COUNT_BITS-1:0] bytes_left_r, bytes_left_nxt;
  logic [1:0]            trailer_left_r, trailer_left_nxt;
  logic                  word_seen_r, word_seen_nxt;
  logic                  in_word_r, in_word_nxt;

  logic       out_valid_r;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       bv_r, bv_nxt;
  logic       ae_r, ae_nxt;
  logic       ce_r, ce_nxt;
  logic       pe_r, pe_nxt;
  logic       inl_r, inl_nxt;

  logic       accept;
  logic       idle;
  logic       start_array;
  phase_t     ph_eff;
  logic       prev_eff;
  logic       seen_eff;
  logic       in_word_eff;
  logic       line_end;
  logic       num_phase;
  logic       count_bad;
  logic [1:0] trailer_dec;
  logic [COUNT_BITS-1:0] args_dec;
  num_ctl_t   num_ctl;
  num_stat_t  num_stat;

  // handshake
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // first byte of a command picks array or inline form
  assign idle        = (phase_r == PH_IDLE);
  assign start_array = idle && (in_byte == CH_STAR);
  assign ph_eff      = idle ? ((in_byte == CH_STAR) ? PH_COUNT : PH_INLINE) : phase_r;
  assign prev_eff    = idle ? 1'b0 : prev_cr_r;
  assign seen_eff    = idle ? 1'b0 : word_seen_r;
  assign in_word_eff = idle ? 1'b0 : in_word_r;
  assign line_end    = prev_eff && (in_byte == CH_LF);
  assign num_phase   = !start_array && ((ph_eff == PH_COUNT) || (ph_eff == PH_LEN));
  assign count_bad   = !num_stat.ok || num_stat.negative || num_stat.zero;
  assign trailer_dec = (trailer_left_r != 2'd0) ? trailer_left_r - 2'd1 : 2'd0;
  assign args_dec    = (args_left_r != '0) ? args_left_r - 1'b1 : '0;

  // number scanner control
  assign num_ctl.advance   = accept;
  assign num_ctl.clr       = start_array || ((ph_eff == PH_ELEM) && (in_byte == CH_DOLLAR));
  assign num_ctl.feed_cr   = num_phase && prev_eff && (in_byte != CH_LF);
  assign num_ctl.feed_byte = num_phase && !line_end && (in_byte != CH_CR);

  rcsp_number u_number (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (num_ctl),
    .in_byte (in_byte),
    .stat    (num_stat)
  );

  // next state
  always_comb begin
    phase_nxt        = phase_r;
    prev_cr_nxt      = prev_cr_r;
    args_left_nxt    = args_left_r;
    bytes_left_nxt   = bytes_left_r;
    trailer_left_nxt = trailer_left_r;
    word_seen_nxt    = word_seen_r;
    in_word_nxt      = in_word_r;
    if (start_array) begin
      phase_nxt   = PH_COUNT;
      prev_cr_nxt = 1'b0;
    end else begin
      case (ph_eff)
        PH_INLINE: begin
          if (line_end) begin
            prev_cr_nxt   = 1'b0;
            word_seen_nxt = 1'b0;
            in_word_nxt   = 1'b0;
            phase_nxt     = PH_IDLE;
          end else begin
            phase_nxt     = PH_INLINE;
            prev_cr_nxt   = (in_byte == CH_CR);
            word_seen_nxt = is_ws(in_byte) ? seen_eff : 1'b1;
            in_word_nxt   = !is_ws(in_byte);
          end
        end
        PH_COUNT: begin
          prev_cr_nxt = !line_end && (in_byte == CH_CR);
          if (line_end) begin
            if (count_bad) begin
              phase_nxt = PH_IDLE;
            end else begin
              args_left_nxt = num_stat.value[COUNT_BITS-1:0];
              phase_nxt     = PH_ELEM;
            end
          end
        end
        PH_ELEM: begin
          prev_cr_nxt = (in_byte == CH_CR);
          phase_nxt   = (in_byte == CH_DOLLAR) ? PH_LEN : PH_BADLINE;
        end
        PH_BADLINE: begin
          prev_cr_nxt = !line_end && (in_byte == CH_CR);
          if (line_end) begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_LEN: begin
          prev_cr_nxt = !line_end && (in_byte == CH_CR);
          if (line_end) begin
            if (!num_stat.ok) begin
              phase_nxt = PH_IDLE;
            end else if (num_stat.negative && !num_stat.zero) begin
              args_left_nxt = args_left_r - 1'b1;
              phase_nxt     = (args_left_r == {{(COUNT_BITS-1){1'b0}}, 1'b1}) ? PH_IDLE : PH_ELEM;
            end else if (num_stat.zero) begin
              trailer_left_nxt = 2'd2;
              phase_nxt        = PH_TRAILER;
            end else begin
              bytes_left_nxt = num_stat.value[COUNT_BITS-1:0];
              phase_nxt      = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          bytes_left_nxt = bytes_left_r - 1'b1;
          if (bytes_left_r == {{(COUNT_BITS-1){1'b0}}, 1'b1}) begin
            trailer_left_nxt = 2'd2;
            phase_nxt        = PH_TRAILER;
          end
        end
        PH_TRAILER: begin
          trailer_left_nxt = trailer_dec;
          if (trailer_dec == 2'd0) begin
            args_left_nxt = args_dec;
            phase_nxt     = (args_dec == '0) ? PH_IDLE : PH_ELEM;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // result flags for this byte
  always_comb begin
    out_byte_nxt = 8'd0;
    bv_nxt       = 1'b0;
    ae_nxt       = 1'b0;
    ce_nxt       = 1'b0;
    pe_nxt       = 1'b0;
    inl_nxt      = 1'b0;
    if (!start_array) begin
      case (ph_eff)
        PH_INLINE: begin
          inl_nxt = 1'b1;
          if (line_end) begin
            ce_nxt = seen_eff;
          end else if (is_ws(in_byte)) begin
            ae_nxt = in_word_eff;
          end else begin
            out_byte_nxt = in_byte;
            bv_nxt       = 1'b1;
          end
        end
        PH_COUNT: begin
          ce_nxt = line_end && count_bad;
          pe_nxt = line_end && count_bad;
        end
        PH_BADLINE: begin
          ce_nxt = line_end;
          pe_nxt = line_end;
        end
        PH_LEN: begin
          if (line_end) begin
            if (!num_stat.ok) begin
              ce_nxt = 1'b1;
              pe_nxt = 1'b1;
            end else if (num_stat.negative && !num_stat.zero) begin
              ae_nxt = 1'b1;
              ce_nxt = (args_left_r == {{(COUNT_BITS-1){1'b0}}, 1'b1});
            end else if (num_stat.zero) begin
              ae_nxt = 1'b1;
            end
          end
        end
        PH_DATA: begin
          out_byte_nxt = in_byte;
          bv_nxt       = 1'b1;
          ae_nxt       = (bytes_left_r == {{(COUNT_BITS-1){1'b0}}, 1'b1});
        end
        PH_TRAILER: begin
          ce_nxt = (trailer_dec == 2'd0) && (args_dec == '0);
        end
        default: begin
          bv_nxt = 1'b0;
        end
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      prev_cr_r      <= 1'b0;
      args_left_r    <= '0;
      bytes_left_r   <= '0;
      trailer_left_r <= 2'd0;
      word_seen_r    <= 1'b0;
      in_word_r      <= 1'b0;
    end else if (accept) begin
      phase_r        <= phase_nxt;
      prev_cr_r      <= prev_cr_nxt;
      args_left_r    <= args_left_nxt;
      bytes_left_r   <= bytes_left_nxt;
      trailer_left_r <= trailer_left_nxt;
      word_seen_r    <= word_seen_nxt;
      in_word_r      <= in_word_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_byte_r <= out_byte_nxt;
      bv_r       <= bv_nxt;
      ae_r       <= ae_nxt;
      ce_r       <= ce_nxt;
      pe_r       <= pe_nxt;
      inl_r      <= inl_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte           = out_byte_r;
  assign out_byte_valid     = bv_r;
  assign out_arg_end        = ae_r;
  assign out_cmd_end        = ce_r;
  assign out_protocol_error = pe_r;
  assign out_inline_form    = inl_r;

`ifndef NO_ASSERTIONS
  // an error always closes its command
  a_err_ends_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_protocol_error |-> out_cmd_end)
    else $error("protocol_error without cmd_end");

  // inline commands are never flagged malformed
  a_inline_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_inline_form |-> !out_protocol_error)
    else $error("protocol_error on inline command");

  // a bulk payload phase always has bytes remaining
  a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> bytes_left_r != '0)
    else $error("data phase with no bytes left");

  // an accepted request always leaves a result on the next edge
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted request produced no result");
`endif

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the request stream command parser
`timescale 1ns / 100ps

module testbench;
  import rcsp_pkg::*;

  // extra character codes used by the stimulus
  localparam logic [7:0] CH_VT      = 8'h0B;
  localparam logic [7:0] CH_FF      = 8'h0C;
  localparam logic [7:0] CH_LOWER_A = 8'h61;

  localparam int QUIET_LIMIT     = 2000;
  localparam int RANDOM_BYTES    = 1400;
  localparam int LONG_HOLD       = 80;

  // one parser output per request byte
  typedef struct packed {
    logic [7:0] data;
    logic       data_valid;
    logic       arg_end;
    logic       cmd_end;
    logic       error;
    logic       inline_form;
  } token_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_arg_end;
  logic       out_cmd_end;
  logic       out_protocol_error;
  logic       out_inline_form;

  resp_command_stream_parser dut (.*);

  always #2 clk = ~clk;

  // parser state as predicted
  phase_t      parse_phase = PH_IDLE;
  logic        line_cr     = 1'b0;
  logic [63:0] num_value   = '0;
  logic        num_neg     = 1'b0;
  num_stage_t  num_stage   = NS_LEAD;
  logic        num_bad     = 1'b0;
  logic [63:0] args_left   = '0;
  logic [63:0] bytes_left  = '0;
  int          trailer_left = 0;
  logic        word_seen   = 1'b0;
  logic        in_word     = 1'b0;

  token_t pending_tokens[$];
  int     error_count  = 0;
  int     bytes_sent   = 0;
  int     quiet_cycles = 0;
  bit     tx_throttle  = 1'b1;
  bit     rx_throttle  = 1'b1;
  int     hold_request = 0;

  function automatic logic blank_char(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic void num_clear();
    num_value = '0;
    num_neg   = 1'b0;
    num_stage = NS_LEAD;
    num_bad   = 1'b0;
  endfunction

  // decimal scan, stoi style, saturating into the bad flag on overflow
  function automatic void num_scan(input logic [7:0] c);
    logic        digit;
    logic [63:0] lim;
    logic [63:0] d;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    case (num_stage)
      NS_LEAD: begin
        if (blank_char(c)) return;
        if (c == CH_PLUS || c == CH_MINUS) begin
          num_neg   = (c == CH_MINUS);
          num_stage = NS_SIGN;
          return;
        end
        if (!digit) begin
          num_bad   = 1'b1;
          num_stage = NS_DONE;
          return;
        end
        num_stage = NS_DIGITS;
      end
      NS_SIGN: begin
        if (!digit) begin
          num_bad   = 1'b1;
          num_stage = NS_DONE;
          return;
        end
        num_stage = NS_DIGITS;
      end
      NS_DIGITS: begin
        if (!digit) begin
          num_stage = NS_DONE;
          return;
        end
      end
      default: return;
    endcase
    if (num_bad) return;
    lim = (64'd1 << (NUMBER_BITS - 1)) - (num_neg ? 64'd0 : 64'd1);
    d   = c - CH_ZERO;
    if (num_value > (lim - d) / 10) begin
      num_bad = 1'b1;
      return;
    end
    num_value = num_value * 10 + d;
  endfunction

  // feeds one byte of a number line, true once cr lf closes it
  function automatic bit num_line(input logic [7:0] c);
    if (line_cr && c == CH_LF) begin
      line_cr = 1'b0;
      return 1'b1;
    end
    if (line_cr) num_scan(CH_CR);
    if (c == CH_CR) begin
      line_cr = 1'b1;
    end else begin
      num_scan(c);
      line_cr = 1'b0;
    end
    return 1'b0;
  endfunction

  function automatic logic num_valid();
    return !num_bad && (num_stage == NS_DIGITS || num_stage == NS_DONE);
  endfunction

  // expected parser output for one accepted request byte
  function automatic token_t tokenize_byte(input logic [7:0] c);
    token_t t;
    logic   consumed;
    t        = '0;
    consumed = 1'b0;
    if (parse_phase == PH_IDLE) begin
      line_cr = 1'b0;
      if (c == CH_STAR) begin
        parse_phase = PH_COUNT;
        num_clear();
        consumed = 1'b1;
      end else begin
        parse_phase = PH_INLINE;
        word_seen   = 1'b0;
        in_word     = 1'b0;
      end
    end
    if (!consumed) begin
      case (parse_phase)
        PH_INLINE: begin
          t.inline_form = 1'b1;
          if (line_cr && c == CH_LF) begin
            line_cr     = 1'b0;
            t.cmd_end   = word_seen;
            word_seen   = 1'b0;
            in_word     = 1'b0;
            parse_phase = PH_IDLE;
          end else begin
            line_cr = (c == CH_CR);
            if (blank_char(c)) begin
              if (in_word) begin
                t.arg_end = 1'b1;
                in_word   = 1'b0;
              end
            end else begin
              t.data       = c;
              t.data_valid = 1'b1;
              in_word      = 1'b1;
              word_seen    = 1'b1;
            end
          end
        end
        PH_COUNT: begin
          if (num_line(c)) begin
            if (!num_valid() || num_neg || num_value == 0) begin
              t.cmd_end   = 1'b1;
              t.error     = 1'b1;
              parse_phase = PH_IDLE;
            end else begin
              args_left   = num_value;
              parse_phase = PH_ELEM;
            end
          end
        end
        PH_ELEM: begin
          line_cr = 1'b0;
          if (c == CH_DOLLAR) begin
            parse_phase = PH_LEN;
            num_clear();
          end else begin
            parse_phase = PH_BADLINE;
            line_cr     = (c == CH_CR);
          end
        end
        PH_BADLINE: begin
          if (line_cr && c == CH_LF) begin
            line_cr     = 1'b0;
            t.cmd_end   = 1'b1;
            t.error     = 1'b1;
            parse_phase = PH_IDLE;
          end else begin
            line_cr = (c == CH_CR);
          end
        end
        PH_LEN: begin
          if (num_line(c)) begin
            if (!num_valid()) begin
              t.cmd_end   = 1'b1;
              t.error     = 1'b1;
              parse_phase = PH_IDLE;
            end else if (num_neg && num_value != 0) begin
              // negative length: empty argument, no data or trailer
              t.arg_end = 1'b1;
              args_left = args_left - 1;
              if (args_left == 0) begin
                t.cmd_end   = 1'b1;
                parse_phase = PH_IDLE;
              end else begin
                parse_phase = PH_ELEM;
              end
            end else if (num_value == 0) begin
              t.arg_end    = 1'b1;
              trailer_left = 2;
              parse_phase  = PH_TRAILER;
            end else begin
              bytes_left  = num_value;
              parse_phase = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          t.data       = c;
          t.data_valid = 1'b1;
          bytes_left   = bytes_left - 1;
          if (bytes_left == 0) begin
            t.arg_end    = 1'b1;
            trailer_left = 2;
            parse_phase  = PH_TRAILER;
          end
        end
        PH_TRAILER: begin
          if (trailer_left > 0) trailer_left--;
          if (trailer_left == 0) begin
            if (args_left > 0) args_left = args_left - 1;
            if (args_left == 0) begin
              t.cmd_end   = 1'b1;
              parse_phase = PH_IDLE;
            end else begin
              parse_phase = PH_ELEM;
            end
          end
        end
        default: parse_phase = PH_IDLE;
      endcase
    end
    return t;
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // idle length: mostly short, now and then long
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  // predict on every accepted request, compare every accepted result
  always @(posedge clk) begin : scoreboard
    token_t got;
    token_t want;
    token_t next_tok;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        next_tok       = tokenize_byte(in_byte);
        pending_tokens = {pending_tokens, next_tok};
      end
      if (out_valid && out_ready) begin
        got = {out_byte, out_byte_valid, out_arg_end, out_cmd_end,
               out_protocol_error, out_inline_form};
        if (pending_tokens.size() == 0) begin
          report_mismatch("result with no request pending");
        end else begin
          want = pending_tokens.pop_front();
          if (got.data !== want.data)
            report_mismatch($sformatf("out_byte %h, want %h", got.data, want.data));
          if (got.data_valid !== want.data_valid)
            report_mismatch($sformatf("out_byte_valid %b, want %b",
                                      got.data_valid, want.data_valid));
          if (got.arg_end !== want.arg_end)
            report_mismatch($sformatf("out_arg_end %b, want %b", got.arg_end, want.arg_end));
          if (got.cmd_end !== want.cmd_end)
            report_mismatch($sformatf("out_cmd_end %b, want %b", got.cmd_end, want.cmd_end));
          if (got.error !== want.error)
            report_mismatch($sformatf("out_protocol_error %b, want %b", got.error, want.error));
          if (got.inline_form !== want.inline_form)
            report_mismatch($sformatf("out_inline_form %b, want %b",
                                      got.inline_form, want.inline_form));
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side ready, with random stalls and the long hold-off on request
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (hold_request > 0) begin
        out_ready <= 1'b0;
        stall_left   = hold_request - 1;
        hold_request = 0;
      end else if (rx_throttle && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        stall_left = gap_len() - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // sends one request byte; called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = (tx_throttle && $urandom_range(0, 3) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_byte  <= 8'($urandom_range(0, 255));
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_line(input string s);
    send_text(s);
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  // inline words, odd whitespace, empty and blank lines
  task automatic test_inline_commands();
    send_line("PING");
    send_line("SET  key\tval\013x\014y ");
    send_line("");
    send_line("  \t");
    send_line("a\015b\nc");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_line("");
  endtask

  // well-formed arrays: data, zero and negative lengths, unchecked trailer
  task automatic test_array_commands();
    send_line("*2");
    send_line("$3");
    send_line("GET");
    send_line("$0");
    send_line("");
    send_line("*3");
    send_line("$-1");
    send_line("$ +2junk");
    send_line("ab");
    send_line("$-2147483648");
    send_line("*1");
    send_line("$2");
    send_text("hiXY");
    send_line("*2");
    send_line("$-0");
    send_line("");
    send_line("$1");
    send_line("\015");
    send_line("*\n+2\015junk");
    send_line("$1");
    send_line("a");
    send_line("$1");
    send_line("b");
  endtask

  // malformed counts, missing dollar, bad lengths
  task automatic test_malformed_commands();
    send_line("*0");
    send_line("*-3");
    send_line("*abc");
    send_line("*");
    send_line("*2147483648");
    send_line("*2147483647");
    send_line("X junk");
    send_line("*1");
    send_line("$2147483648");
    send_line("*1");
    send_line("$-2147483649");
    send_line("*1");
    send_line("$x");
  endtask

  task automatic send_random_array();
    int n;
    int len;
    int r;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 9) : $urandom_range(1, 4);
    send_line(($urandom_range(0, 3) == 0) ? $sformatf("* +%0d", n) : $sformatf("*%0d", n));
    repeat (n) begin
      r = $urandom_range(0, 19);
      if (r == 0) len = -int'($urandom_range(1, 5));
      else if (r == 1) len = 0;
      else if (r == 2) len = $urandom_range(20, 60);
      else len = $urandom_range(1, 12);
      send_line($sformatf("$%0d", len));
      if (len >= 0) begin
        repeat (len) send_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0) begin
          send_byte(8'($urandom_range(0, 255)));
          send_byte(8'($urandom_range(0, 255)));
        end else begin
          send_line("");
        end
      end
    end
  endtask

  task automatic send_random_inline();
    int         words;
    logic [7:0] c;
    words = $urandom_range(1, 5);
    for (int w = 0; w < words; w++) begin
      if (w > 0 || $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 2)) begin
          case ($urandom_range(0, 5))
            0: send_byte(CH_SPACE);
            1: send_byte(CH_TAB);
            2: send_byte(CH_VT);
            3: send_byte(CH_FF);
            4: send_byte(CH_LF);
            default: send_byte(CH_CR);
          endcase
        end
      end
      repeat ($urandom_range(1, 6)) begin
        c = 8'($urandom_range(0, 255));
        if (blank_char(c) || c == CH_STAR) c = CH_LOWER_A + 8'($urandom_range(0, 25));
        send_byte(c);
      end
    end
    send_line("");
  endtask

  task automatic send_broken_command();
    logic [7:0] c;
    case ($urandom_range(0, 5))
      0: begin
        repeat ($urandom_range(1, 16)) send_byte(8'($urandom_range(0, 255)));
        send_line("");
      end
      1: begin
        case ($urandom_range(0, 4))
          0: send_line("*0");
          1: send_line($sformatf("*-%0d", $urandom_range(1, 9)));
          2: send_line("*x1");
          3: send_line("*+");
          default: send_line("*2147483648");
        endcase
      end
      2: begin
        send_line("*2");
        send_line("$1");
        send_line("z");
        c = 8'($urandom_range(0, 255));
        if (c == CH_DOLLAR) c = CH_STAR;
        send_byte(c);
        send_line("2");
      end
      3: begin
        send_line("*1");
        case ($urandom_range(0, 4))
          0: send_line("$");
          1: send_line("$-");
          2: send_line("$ +x");
          3: send_line("$99999999999");
          default: send_line("$-2147483649");
        endcase
      end
      4: begin
        // cut short: the next command is taken as data
        send_line("*3");
        send_line("$5");
        send_text("ab");
      end
      default: begin
        send_line("");
        send_line("\n\015x \n");
      end
    endcase
  endtask

  task automatic test_random_traffic();
    int start;
    int kind;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      if ($urandom_range(0, 7) == 0) begin
        tx_throttle = 1'($urandom_range(0, 1));
        rx_throttle = 1'($urandom_range(0, 1));
      end
      kind = $urandom_range(0, 9);
      if (kind < 6) send_random_array();
      else if (kind < 8) send_random_inline();
      else send_broken_command();
    end
    tx_throttle = 1'b1;
    rx_throttle = 1'b1;
  endtask

  // long hold on the result side while requests keep coming
  task automatic test_output_stall();
    tx_throttle  = 1'b0;
    rx_throttle  = 1'b0;
    hold_request = LONG_HOLD;
    send_line("*2");
    send_line("$4");
    send_line("full");
    send_line("$-1");
    send_line("STALL the output");
    tx_throttle = 1'b1;
    rx_throttle = 1'b1;
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_byte  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_inline_commands();
    test_array_commands();
    test_malformed_commands();
    test_random_traffic();
    test_output_stall();

    in_valid    <= 1'b0;
    rx_throttle = 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rcsp_pkg.sv
rtl/rcsp_number.sv
rtl/resp_command_stream_parser.sv
tb/testbench.sv
